// ===== rtl/scp_pkg.sv =====
// shared widths and types for the segment crossing point pipeline
// no dependencies
package scp_pkg;

	localparam int CW  = 16;           // coordinate width
	localparam int DW  = CW + 1;       // coordinate difference width
	localparam int PW  = 2 * DW;       // product of two differences
	localparam int XW  = PW + 1;       // cross product
	localparam int MW  = 2 * CW + 1;   // cross product magnitude
	localparam int LW  = 17;           // low slice of magnitude for split multiply
	localparam int HW  = MW - LW;      // high slice
	localparam int EW  = MW + 1;       // denominator d1 + d2
	localparam int NW  = CW + MW;      // numerator |delta| * d1
	localparam int RW  = NW + 1;       // running remainder
	localparam int QW  = CW;           // quotient magnitude
	localparam int NL  = 3;            // lanes: x, height, z
	localparam int DS  = QW;           // divider stages, one quotient bit each
	localparam int IW  = 10 * CW;      // input tdata width
	localparam int OW  = NL * CW;      // output tdata width

	localparam int LX = 0;
	localparam int LY = 1;
	localparam int LZ = 2;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] diff_t;

	typedef struct packed {
		logic                  hit;
		logic                  degen;
		logic [NL-1:0]         neg;
		logic [NL-1:0][CW-1:0] base;
	} ctl_t;

endpackage

// ===== rtl/segment_crossing_point.sv =====
// segment crossing point: bounding box, cross product tests, interpolated point
// depends on scp_pkg
//
// usage
//  s_tdata carries segment AB (x, height, z) and segment CD (x, z) as signed
//  16-bit fields; one transaction per segment pair
//  m_tuser carries the crosses and degenerate flags, m_tdata the point
//  (x, height, z), zero when the segments do not meet, A on collinear overlap
//  throughput is one pair per cycle while results are taken; from the s_tdata
//  transaction to m_tvalid a pair passes six stages of differences, products, cross
//  products, tests and a split multiply, then a restoring divider that
//  resolves one quotient bit per stage over 16 stages, then the output register
//  the whole pipeline advances when the output register is empty or taken;
//  while m_tready is low with a result waiting, every stage holds and
//  s_tready drops, so nothing is lost or repeated
//  arst_n clears all valid bits at once; payload registers are not reset
module segment_crossing_point
	import scp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// first_start_x, first_start_height, first_start_z, first_end_x,
	// first_end_height, first_end_z, second_start_x, second_start_z,
	// second_end_x, second_end_z
	input  logic [IW-1:0] s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// crosses, degenerate
	output logic [1:0]    m_tuser,
	// cross_x, cross_height, cross_z
	output logic [OW-1:0] m_tdata
);

	logic ce;
	coord_t ax, ay, az, bx, by, bz, cx, cz, dx, dz;
	logic bbox;

	// stage 1
	logic                  v_s1, bbox_s1;
	diff_t                 dcx_s1, dcz_s1, acx_s1, acz_s1, bcx_s1, bcz_s1;
	diff_t                 cax_s1, caz_s1, dax_s1, daz_s1;
	diff_t [NL-1:0]        dl_s1;
	logic [NL-1:0][CW-1:0] base_s1;
	// stage 2
	logic                  v_s2, bbox_s2;
	logic signed [PW-1:0]  pr_s2 [8];
	diff_t [NL-1:0]        dl_s2;
	logic [NL-1:0][CW-1:0] base_s2;
	// stage 3
	logic                  v_s3, bbox_s3;
	logic signed [XW-1:0]  cr_s3 [4];
	diff_t [NL-1:0]        dl_s3;
	logic [NL-1:0][CW-1:0] base_s3;
	// stage 4
	logic                  v_s4, hit_s4;
	logic [MW-1:0]         d1_s4, d2_s4;
	logic [CW-1:0]         mag_s4 [NL];
	logic [NL-1:0]         neg_s4;
	logic [NL-1:0][CW-1:0] base_s4;
	// stage 5
	logic                  v_s5;
	logic [EW-1:0]         den_s5;
	logic [CW+LW-1:0]      mlo_s5 [NL];
	logic [CW+HW-1:0]      mhi_s5 [NL];
	ctl_t                  ctl_s5;
	// stage 6
	logic                  v_s6;
	logic [EW-1:0]         den_s6;
	logic [NW-1:0]         num_s6 [NL];
	ctl_t                  ctl_s6;
	// divider stages
	logic                  v_dv   [DS];
	logic [EW-1:0]         den_dv [DS];
	ctl_t                  ctl_dv [DS];
	logic [RW-1:0]         rem_dv [DS][NL];
	logic [QW-1:0]         q_dv   [DS][NL];
	logic [RW-1:0]         rem_in [DS][NL];
	logic [QW-1:0]         q_in   [DS][NL];
	logic [EW-1:0]         den_in [DS];
	logic [RW-1:0]         rem_nx [DS][NL];
	logic [QW-1:0]         q_nx   [DS][NL];
	// output
	logic                  m_tvalid_q;
	logic [1:0]            m_tuser_q;
	logic [OW-1:0]         m_tdata_q;
	logic [OW-1:0]         pt;

	function automatic coord_t smax(coord_t a, coord_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic coord_t smin(coord_t a, coord_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic opposed(logic signed [XW-1:0] a, logic signed [XW-1:0] b);
		return ((a > 0) && (b < 0)) || ((a < 0) && (b > 0));
	endfunction

	assign ce       = !m_tvalid_q || m_tready;
	assign s_tready = ce;

	assign ax = s_tdata[0*CW +: CW];
	assign ay = s_tdata[1*CW +: CW];
	assign az = s_tdata[2*CW +: CW];
	assign bx = s_tdata[3*CW +: CW];
	assign by = s_tdata[4*CW +: CW];
	assign bz = s_tdata[5*CW +: CW];
	assign cx = s_tdata[6*CW +: CW];
	assign cz = s_tdata[7*CW +: CW];
	assign dx = s_tdata[8*CW +: CW];
	assign dz = s_tdata[9*CW +: CW];

	assign bbox = (smax(ax, bx) >= smin(cx, dx)) && (smax(az, bz) >= smin(cz, dz)) &&
		(smax(cx, dx) >= smin(ax, bx)) && (smax(cz, dz) >= smin(az, bz));

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int j = 0; j < DS; j++) v_dv[j] <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_dv[0] <= v_s6;
			for (int j = 1; j < DS; j++) v_dv[j] <= v_dv[j-1];
			m_tvalid_q <= v_dv[DS-1];
		end
	end

	// front stages
	always_ff @(posedge clk) begin
		if (ce) begin
			bbox_s1    <= bbox;
			dcx_s1     <= DW'(dx) - DW'(cx);
			dcz_s1     <= DW'(dz) - DW'(cz);
			acx_s1     <= DW'(ax) - DW'(cx);
			acz_s1     <= DW'(az) - DW'(cz);
			bcx_s1     <= DW'(bx) - DW'(cx);
			bcz_s1     <= DW'(bz) - DW'(cz);
			cax_s1     <= DW'(cx) - DW'(ax);
			caz_s1     <= DW'(cz) - DW'(az);
			dax_s1     <= DW'(dx) - DW'(ax);
			daz_s1     <= DW'(dz) - DW'(az);
			dl_s1[LX]  <= DW'(bx) - DW'(ax);
			dl_s1[LY]  <= DW'(by) - DW'(ay);
			dl_s1[LZ]  <= DW'(bz) - DW'(az);
			base_s1[LX] <= ax;
			base_s1[LY] <= ay;
			base_s1[LZ] <= az;

			bbox_s2  <= bbox_s1;
			pr_s2[0] <= acz_s1 * dcx_s1;
			pr_s2[1] <= acx_s1 * dcz_s1;
			pr_s2[2] <= dcz_s1 * bcx_s1;
			pr_s2[3] <= dcx_s1 * bcz_s1;
			pr_s2[4] <= caz_s1 * dl_s1[LX];
			pr_s2[5] <= cax_s1 * dl_s1[LZ];
			pr_s2[6] <= dl_s1[LZ] * dax_s1;
			pr_s2[7] <= dl_s1[LX] * daz_s1;
			dl_s2    <= dl_s1;
			base_s2  <= base_s1;

			bbox_s3 <= bbox_s2;
			for (int i = 0; i < 4; i++)
				cr_s3[i] <= XW'(pr_s2[2*i]) - XW'(pr_s2[2*i+1]);
			dl_s3   <= dl_s2;
			base_s3 <= base_s2;

			hit_s4 <= bbox_s3 && !opposed(cr_s3[0], cr_s3[1]) && !opposed(cr_s3[2], cr_s3[3]);
			d1_s4  <= MW'((cr_s3[0] < 0) ? -cr_s3[0] : cr_s3[0]);
			d2_s4  <= MW'((cr_s3[1] < 0) ? -cr_s3[1] : cr_s3[1]);
			for (int l = 0; l < NL; l++) begin
				neg_s4[l] <= dl_s3[l][DW-1];
				mag_s4[l] <= CW'(dl_s3[l][DW-1] ? -dl_s3[l] : dl_s3[l]);
			end
			base_s4 <= base_s3;

			den_s5 <= EW'(d1_s4) + EW'(d2_s4);
			for (int l = 0; l < NL; l++) begin
				mlo_s5[l] <= (CW+LW)'(mag_s4[l]) * (CW+LW)'(d1_s4[LW-1:0]);
				mhi_s5[l] <= (CW+HW)'(mag_s4[l]) * (CW+HW)'(d1_s4[MW-1:LW]);
			end
			ctl_s5.hit   <= hit_s4;
			ctl_s5.degen <= 1'b0;
			ctl_s5.neg   <= neg_s4;
			ctl_s5.base  <= base_s4;

			den_s6 <= den_s5;
			for (int l = 0; l < NL; l++)
				num_s6[l] <= (NW'(mhi_s5[l]) << LW) + NW'(mlo_s5[l]);
			ctl_s6.hit   <= ctl_s5.hit;
			ctl_s6.neg   <= ctl_s5.neg;
			ctl_s6.base  <= ctl_s5.base;
			ctl_s6.degen <= ctl_s5.hit && (den_s5 == '0);
		end
	end

	// restoring divider, one quotient bit per stage
	always_comb begin
		for (int j = 0; j < DS; j++) begin
			den_in[j] = (j == 0) ? den_s6 : den_dv[(j == 0) ? 0 : j-1];
			for (int l = 0; l < NL; l++) begin
				rem_in[j][l] = (j == 0) ? RW'(num_s6[l]) : rem_dv[(j == 0) ? 0 : j-1][l];
				q_in[j][l]   = (j == 0) ? '0 : q_dv[(j == 0) ? 0 : j-1][l];
			end
		end
		for (int j = 0; j < DS; j++) begin
			for (int l = 0; l < NL; l++) begin
				rem_nx[j][l] = rem_in[j][l];
				q_nx[j][l]   = q_in[j][l];
				if (rem_in[j][l] >= (RW'(den_in[j]) << (DS-1-j))) begin
					rem_nx[j][l]        = rem_in[j][l] - (RW'(den_in[j]) << (DS-1-j));
					q_nx[j][l][QW-1-j]  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ctl_dv[0] <= ctl_s6;
			den_dv[0] <= den_s6;
			for (int j = 1; j < DS; j++) begin
				ctl_dv[j] <= ctl_dv[j-1];
				den_dv[j] <= den_dv[j-1];
			end
			for (int j = 0; j < DS; j++) begin
				for (int l = 0; l < NL; l++) begin
					rem_dv[j][l] <= rem_nx[j][l];
					q_dv[j][l]   <= q_nx[j][l];
				end
			end
		end
	end

	// signed offset from A, applied in the output stage
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			if (!ctl_dv[DS-1].hit)
				pt[l*CW +: CW] = '0;
			else if (ctl_dv[DS-1].degen)
				pt[l*CW +: CW] = ctl_dv[DS-1].base[l];
			else if (ctl_dv[DS-1].neg[l])
				pt[l*CW +: CW] = ctl_dv[DS-1].base[l] - q_dv[DS-1][l];
			else
				pt[l*CW +: CW] = ctl_dv[DS-1].base[l] + q_dv[DS-1][l];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			m_tuser_q <= {ctl_dv[DS-1].degen, ctl_dv[DS-1].hit};
			m_tdata_q <= pt;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule
